/* design/score_to_palette_color_assert.svh */
// Assertion macros for the score-to-palette color block.
`ifndef SCORE_TO_PALETTE_COLOR_ASSERT_SVH
`define SCORE_TO_PALETTE_COLOR_ASSERT_SVH
`ifndef SYNTHESIS
`define STP_ASSERT_IMPL(lbl, ante, cons) lbl: assert property (@(posedge clk) \
  disable iff (rst) (ante) |-> (cons)) else $error("score_to_palette_color check failed");
`define STP_ASSERT_NEXT(lbl, ante, cons) lbl: assert property (@(posedge clk) \
  disable iff (rst) (ante) |=> (cons)) else $error("score_to_palette_color check failed");
`else
`define STP_ASSERT_IMPL(lbl, ante, cons)
`define STP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* design/stp_pkg.sv */
// Shared constants, types and the viridis stop table.
`timescale 1ns / 1ps
package stp_pkg;
  localparam int FRAC_BITS  = 16;
  localparam int SCORE_W    = 32;
  localparam int DIFF_W     = SCORE_W + 2;
  localparam int MAG_W      = SCORE_W + 1;
  localparam int REM_W      = MAG_W + 1;
  localparam int T_W        = FRAC_BITS + 1;
  localparam int STOP_COUNT = 15;
  localparam int CH_W       = 8;
  localparam int DIV_STEPS  = FRAC_BITS + 1;

  localparam logic [1:0] REG_RANGE_LOW  = 2'd0;
  localparam logic [1:0] REG_RANGE_HIGH = 2'd1;
  localparam logic [1:0] REG_PALETTE    = 2'd2;

  localparam logic [CH_W-1:0] GRAY_LEVEL = 8'd128;

  localparam int unsigned VIRIDIS_MIL [STOP_COUNT][3] = '{
    '{267004, 4874, 329415}, '{282323, 116575, 435773}, '{268510, 224401, 509616},
    '{236609, 317321, 541854}, '{199430, 401669, 553693}, '{163625, 471133, 558148},
    '{134692, 535825, 555298}, '{119428, 598863, 542846}, '{143343, 658636, 517093},
    '{216827, 715888, 474708}, '{327963, 769423, 412402}, '{468378, 817338, 328506},
    '{626786, 859153, 222990}, '{789888, 892602, 104888}, '{959347, 908551, 118128}
  };

  typedef struct packed {
    logic gray;
    logic zero_t;
    logic sat;
    logic palette;
  } side_t;
endpackage

/* design/score_to_palette_color.sv */
// Top level: maps a signed score to an RGB color through a deep pipeline.
// Stages in order: score capture, differences, divider setup, divider steps, fraction clamp, palette stages.
// Throughput: one score per clock; busy stays low, the pipeline never stalls.
// The fraction divider sets the depth: one quotient bit per stage, 17 stages.
// Reset: synchronous, clears all valid bits and the range and palette registers.
// Results appear for one cycle with done high; the receiver cannot hold them off.
`timescale 1ns / 1ps
module score_to_palette_color (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [stp_pkg::SCORE_W-1:0] score,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [stp_pkg::SCORE_W-1:0]       cfg_data,
  output logic                              done,
  output logic [stp_pkg::CH_W-1:0]          red,
  output logic [stp_pkg::CH_W-1:0]          green,
  output logic [stp_pkg::CH_W-1:0]          blue
);
  import stp_pkg::*;

  localparam int LATENCY = FRAC_BITS + 7;

  // configuration registers
  logic signed [SCORE_W-1:0] range_low;
  logic signed [SCORE_W-1:0] range_high;
  logic                      palette;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_low  <= '0;
      range_high <= '0;
      palette    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RANGE_LOW:  range_low  <= cfg_data;
        REG_RANGE_HIGH: range_high <= cfg_data;
        REG_PALETTE:    palette    <= cfg_data[0];
        default:        ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage 0: capture the score
  logic                      s0_valid;
  logic signed [SCORE_W-1:0] s0_score;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= start && !busy;
    end
    s0_score <= score;
  end

  // stage 1: exact differences and their magnitudes
  logic signed [DIFF_W-1:0] num;
  logic signed [DIFF_W-1:0] den;
  logic [DIFF_W-1:0]        an_full;
  logic [DIFF_W-1:0]        ad_full;

  always_comb begin
    num = DIFF_W'(s0_score) - DIFF_W'(range_low);
    den = DIFF_W'(range_high) - DIFF_W'(range_low);
    an_full = num[DIFF_W-1] ? -num : num;
    ad_full = den[DIFF_W-1] ? -den : den;
  end

  logic             s1_valid;
  logic [MAG_W-1:0] s1_an;
  logic [MAG_W-1:0] s1_ad;
  side_t            s1_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s0_valid;
    end
    s1_an           <= an_full[MAG_W-1:0];
    s1_ad           <= ad_full[MAG_W-1:0];
    s1_side.gray    <= den == '0;
    s1_side.zero_t  <= (num == '0) || (num[DIFF_W-1] != den[DIFF_W-1]);
    s1_side.sat     <= 1'b0;
    s1_side.palette <= palette;
  end

  // stage 2: flag quotients of two or more, which clamp to one
  logic             dv_valid [DIV_STEPS+1];
  logic [REM_W-1:0] dv_rem   [DIV_STEPS+1];
  logic [MAG_W-1:0] dv_den   [DIV_STEPS+1];
  logic [T_W-1:0]   dv_quo   [DIV_STEPS+1];
  side_t            dv_side  [DIV_STEPS+1];
  side_t            dv0_side;

  always_comb begin
    dv0_side     = s1_side;
    dv0_side.sat = {1'b0, s1_an} >= {s1_ad, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else begin
      dv_valid[0] <= s1_valid;
    end
    dv_rem[0]  <= {1'b0, s1_an};
    dv_den[0]  <= s1_ad;
    dv_quo[0]  <= '0;
    dv_side[0] <= dv0_side;
  end

  // divider: one quotient bit per stage, most significant first
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    stp_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (dv_valid[i]),
      .in_rem    (dv_rem[i]),
      .in_den    (dv_den[i]),
      .in_quo    (dv_quo[i]),
      .in_side   (dv_side[i]),
      .out_valid (dv_valid[i+1]),
      .out_rem   (dv_rem[i+1]),
      .out_den   (dv_den[i+1]),
      .out_quo   (dv_quo[i+1]),
      .out_side  (dv_side[i+1])
    );
  end

  // fraction stage: clamp t to [0, 1]
  localparam logic [T_W-1:0] T_ONE = T_W'(1) << FRAC_BITS;

  logic           t_valid;
  logic [T_W-1:0] t_val;
  logic           t_gray;
  logic           t_pal;
  side_t          last_side;
  logic [T_W-1:0] last_quo;

  assign last_side = dv_side[DIV_STEPS];
  assign last_quo  = dv_quo[DIV_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      t_valid <= 1'b0;
    end else begin
      t_valid <= dv_valid[DIV_STEPS];
    end
    if (last_side.zero_t) begin
      t_val <= '0;
    end else if (last_side.sat || last_quo > T_ONE) begin
      t_val <= T_ONE;
    end else begin
      t_val <= last_quo;
    end
    t_gray <= last_side.gray;
    t_pal  <= last_side.palette;
  end

  // palette stages drive the result ports
  stp_color u_color (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (t_valid),
    .in_t       (t_val),
    .in_gray    (t_gray),
    .in_palette (t_pal),
    .done       (done),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

  // helpers for the checks below
  logic range_empty;
  logic out_gray;
  logic out_has_full;

  assign range_empty  = range_low == range_high;
  assign out_gray     = red == GRAY_LEVEL && green == GRAY_LEVEL && blue == GRAY_LEVEL;
  assign out_has_full = red == 8'hFF || green == 8'hFF || blue == 8'hFF;

  `include "score_to_palette_color_assert.svh"

  // every done strobe must trace back to a start at the pipeline latency
  `STP_ASSERT_IMPL(a_done_follows_start, done, $past(start, LATENCY))
  // an empty range always yields mid gray
  `STP_ASSERT_IMPL(a_gray_on_empty, done && range_empty, out_gray)
  // rainbow colors always have at least one channel at full scale
  `STP_ASSERT_IMPL(a_rainbow_full, done && palette && !range_empty, out_has_full)
  // the clamped fraction never exceeds one
  `STP_ASSERT_NEXT(a_t_bounded, t_valid, $past(t_val) <= T_ONE)
endmodule

/* design/stp_div_step.sv */
// One restoring division step of the fraction divider.
`timescale 1ns / 1ps
module stp_div_step (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [stp_pkg::REM_W-1:0]     in_rem,
  input  logic [stp_pkg::MAG_W-1:0]     in_den,
  input  logic [stp_pkg::T_W-1:0]       in_quo,
  input  stp_pkg::side_t                in_side,
  output logic                          out_valid,
  output logic [stp_pkg::REM_W-1:0]     out_rem,
  output logic [stp_pkg::MAG_W-1:0]     out_den,
  output logic [stp_pkg::T_W-1:0]       out_quo,
  output stp_pkg::side_t                out_side
);
  import stp_pkg::*;

  logic             take;
  logic [REM_W-1:0] diff;

  always_comb begin
    take = in_rem >= {1'b0, in_den};
    diff = take ? (in_rem - {1'b0, in_den}) : in_rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_rem  <= {diff[REM_W-2:0], 1'b0};
    out_den  <= in_den;
    out_quo  <= {in_quo[T_W-2:0], take};
    out_side <= in_side;
  end
endmodule

/* design/stp_color.sv */
// Palette stages: viridis interpolation, rainbow segments or mid gray, then 8-bit scaling.
`timescale 1ns / 1ps
module stp_color (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [stp_pkg::T_W-1:0]      in_t,
  input  logic                         in_gray,
  input  logic                         in_palette,
  output logic                         done,
  output logic [stp_pkg::CH_W-1:0]     red,
  output logic [stp_pkg::CH_W-1:0]     green,
  output logic [stp_pkg::CH_W-1:0]     blue
);
  import stp_pkg::*;

  localparam int F  = FRAC_BITS;
  localparam int AW = 2 * F;

  logic [F-1:0] stop_tab [STOP_COUNT][3];

  for (genvar k = 0; k < STOP_COUNT; k++) begin : g_stop
    for (genvar c = 0; c < 3; c++) begin : g_ch
      assign stop_tab[k][c] = F'(((64'(VIRIDIS_MIL[k][c]) << F) + 64'd500000) / 64'd1000000);
    end
  end

  // stage A: interpolation products and rainbow segment
  logic [F+3:0] scaled;
  logic [3:0]   idx;
  logic [3:0]   idx_n;
  logic [F-1:0] frac;
  logic [F+2:0] hue;
  logic [AW-1:0] acc_next [3];

  always_comb begin
    scaled = ({3'b000, in_t} << 4) - ({3'b000, in_t} << 1);
    idx    = scaled[F+3:F];
    frac   = scaled[F-1:0];
    idx_n  = idx + 4'd1;
    hue    = ({2'b00, in_t} << 2) + {2'b00, in_t};
  end

  for (genvar c = 0; c < 3; c++) begin : g_mac
    logic [F-1:0]        c1;
    logic [F-1:0]        c2;
    logic signed [F+1:0] dlt;
    logic signed [AW+2:0] sum;
    always_comb begin
      if (idx >= 4'(STOP_COUNT - 1)) begin
        c1 = stop_tab[STOP_COUNT-1][c];
        c2 = stop_tab[STOP_COUNT-1][c];
      end else begin
        c1 = stop_tab[idx][c];
        c2 = stop_tab[idx_n][c];
      end
      dlt = $signed({2'b00, c2}) - $signed({2'b00, c1});
      sum = $signed({3'b000, c1, {F{1'b0}}}) + (AW+3)'(dlt * $signed({1'b0, frac}));
      acc_next[c] = sum[AW-1:0];
    end
  end

  logic          a_valid;
  logic          a_gray;
  logic          a_pal;
  logic [AW-1:0] a_acc [3];
  logic [2:0]    a_seg;
  logic [F-1:0]  a_hf;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
    a_gray <= in_gray;
    a_pal  <= in_palette;
    a_acc  <= acc_next;
    a_seg  <= hue[F+2:F];
    a_hf   <= hue[F-1:0];
  end

  // stage B: scale by 255 and pick the channels
  logic [CH_W-1:0] vir [3];
  logic [CH_W-1:0] v;
  logic [CH_W-1:0] q;
  logic [F+7:0]    vm;
  logic [F:0]      qf;
  logic [F+8:0]    qm;
  logic [CH_W-1:0] r_next;
  logic [CH_W-1:0] g_next;
  logic [CH_W-1:0] b_next;

  for (genvar c = 0; c < 3; c++) begin : g_scale
    logic [AW+7:0] m;
    always_comb begin
      m = {a_acc[c], 8'd0} - {8'd0, a_acc[c]};
      vir[c] = m[AW+7:AW];
    end
  end

  always_comb begin
    vm = {a_hf, 8'd0} - {8'd0, a_hf};
    v  = vm[F+7:F];
    qf = (T_W'(1) << F) - {1'b0, a_hf};
    qm = {qf, 8'd0} - {8'd0, qf};
    q  = qm[F+7:F];
    if (a_gray) begin
      r_next = GRAY_LEVEL;
      g_next = GRAY_LEVEL;
      b_next = GRAY_LEVEL;
    end else if (!a_pal) begin
      r_next = vir[0];
      g_next = vir[1];
      b_next = vir[2];
    end else begin
      case (a_seg)
        3'd0:    begin r_next = 8'hFF; g_next = v;     b_next = 8'h00; end
        3'd1:    begin r_next = q;     g_next = 8'hFF; b_next = 8'h00; end
        3'd2:    begin r_next = 8'h00; g_next = 8'hFF; b_next = v;     end
        3'd3:    begin r_next = 8'h00; g_next = q;     b_next = 8'hFF; end
        3'd4:    begin r_next = v;     g_next = 8'h00; b_next = 8'hFF; end
        default: begin r_next = 8'hFF; g_next = 8'h00; b_next = 8'hFF; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= a_valid;
    end
    red   <= r_next;
    green <= g_next;
    blue  <= b_next;
  end
endmodule
